// File: hdl/character_row_dot_stretcher_assert.svh
// assertion macros for the character row dot stretcher
// used by the top level only; needs a clock and an active-high reset
`ifndef CHARACTER_ROW_DOT_STRETCHER_ASSERT_SVH
`define CHARACTER_ROW_DOT_STRETCHER_ASSERT_SVH

// same-cycle implication
`define CRDS_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crds check failed");

// next-cycle implication
`define CRDS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crds check failed");

`endif

// File: hdl/crds_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the scan row mapping of the dot stretcher
// no dependencies
package crds_pkg;

   localparam int GLYPH_ROWS     = 16;
   localparam int CELL_SCAN_ROWS = 10;
   localparam int GLYPH_COUNT    = 128;
   localparam int STORE_DEPTH    = GLYPH_COUNT * GLYPH_ROWS;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int ROW_W          = $clog2(GLYPH_ROWS);
   localparam int CODE_W         = 8;
   localparam int GLYPH_SEL_W    = $clog2(GLYPH_COUNT);
   localparam int SCAN_W         = 4;
   localparam int BYTE_W         = 8;
   localparam int PIX_W          = 20;
   localparam int CNT_W          = 5;
   localparam int NARROW_PIX     = 10;
   localparam int WIDE_PIX       = 20;
   localparam int REQ_DATA_W     = 40;
   localparam int RSP_DATA_W     = 32;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      LINE_DH_BOTTOM = 2'd0,
      LINE_DH_TOP    = 2'd1,
      LINE_DWIDTH    = 2'd2,
      LINE_NORMAL    = 2'd3
   } line_type_type;

   // sideband carried with each render item
   typedef struct packed {
      logic dbl;
      logic inv;
   } ctl_type;

   // scan row to store entry; glyph row 0 sits in the last entry
   function automatic logic [ROW_W-1:0] glyph_entry(input logic [SCAN_W-1:0] scan,
                                                    input logic [1:0] kind);
      logic [ROW_W-1:0] r;
      case (kind)
         LINE_DH_BOTTOM: r = ROW_W'({1'b0, scan[SCAN_W-1:1]}) + ROW_W'(CELL_SCAN_ROWS / 2);
         LINE_DH_TOP:    r = ROW_W'({1'b0, scan[SCAN_W-1:1]});
         default:        r = ROW_W'(scan);
      endcase
      return (r == '0) ? ROW_W'(GLYPH_ROWS - 1) : r - ROW_W'(1);
   endfunction

endpackage

// File: hdl/crds_map.sv
`timescale 1ns / 1ps
// first stage: store address and control flags of a render item
// depends on crds_pkg
module crds_map import crds_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [CODE_W-1:0]    char_code,
   input  logic [SCAN_W-1:0]    scan_row,
   input  logic [1:0]           line_type,
   input  logic                 reverse_mode,
   output logic                 s1_valid,
   output logic [ADDR_W-1:0]    s1_addr,
   output ctl_type              s1_ctl
);

   logic              valid_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   ctl_type           ctl_ff, ctl_in;

   // glyph select and row mapping
   always_comb begin
      addr_in    = {char_code[GLYPH_SEL_W-1:0], glyph_entry(scan_row, line_type)};
      ctl_in.dbl = (line_type == LINE_DWIDTH);
      ctl_in.inv = reverse_mode & char_code[CODE_W-1];
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         addr_ff <= addr_in;
         ctl_ff  <= ctl_in;
      end
   end

   assign s1_valid = valid_ff;
   assign s1_addr  = addr_ff;
   assign s1_ctl   = ctl_ff;

endmodule

// File: hdl/crds_store.sv
`timescale 1ns / 1ps
// second stage: glyph store, one write port and one registered read port
// depends on crds_pkg
module crds_store import crds_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [BYTE_W-1:0]    wr_data,
   input  logic                 s1_valid,
   input  logic [ADDR_W-1:0]    s1_addr,
   input  ctl_type              s1_ctl,
   output logic                 s2_valid,
   output logic [BYTE_W-1:0]    s2_byte,
   output ctl_type              s2_ctl
);

   logic [BYTE_W-1:0] mem [STORE_DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic              valid_ff;
   ctl_type           ctl_ff;

   // load writes land at acceptance; a read on the same edge sees the old byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (advance) begin
         rd_data_ff <= mem[s1_addr];
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= s1_valid;
      end
   end

   // control flags follow the read
   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff <= s1_ctl;
      end
   end

   assign s2_valid = valid_ff;
   assign s2_byte  = rd_data_ff;
   assign s2_ctl   = ctl_ff;

endmodule

// File: hdl/crds_stretch.sv
`timescale 1ns / 1ps
// third stage: dot stretching, padding, width doubling and inversion
// depends on crds_pkg
module crds_stretch import crds_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 s2_valid,
   input  logic [BYTE_W-1:0]    s2_byte,
   input  ctl_type              s2_ctl,
   output logic                 s3_valid,
   output logic [PIX_W-1:0]     s3_pixel_row,
   output logic [CNT_W-1:0]     s3_pixel_count
);

   logic              valid_ff;
   logic [PIX_W-1:0]  pix_ff, pix_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] dot;
   logic [BYTE_W-1:0] left;
   logic [PIX_W-1:0]  narrow;
   logic [PIX_W-1:0]  wide;

   // dot k is byte bit 7-k; each row starts with a dark left neighbour
   always_comb begin
      narrow = '0;
      wide   = '0;
      for (int k = 0; k < BYTE_W; k++) begin
         dot[k] = s2_byte[BYTE_W-1-k];
      end
      left = {dot[BYTE_W-2:0], 1'b0};
      for (int k = 0; k < BYTE_W; k++) begin
         narrow[k]    = dot[k] | left[k];
         wide[2*k]    = dot[k] | left[k];
         wide[2*k+1]  = dot[k];
      end
      // pad with the last dot
      narrow[NARROW_PIX-1:BYTE_W]   = {2{s2_byte[0]}};
      wide[WIDE_PIX-1:2*BYTE_W]     = {4{s2_byte[0]}};
      if (s2_ctl.dbl) begin
         pix_in = wide ^ {PIX_W{s2_ctl.inv}};
         cnt_in = CNT_W'(WIDE_PIX);
      end else begin
         pix_in = narrow ^ {{(PIX_W-NARROW_PIX){1'b0}}, {NARROW_PIX{s2_ctl.inv}}};
         cnt_in = CNT_W'(NARROW_PIX);
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= s2_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (advance) begin
         pix_ff <= pix_in;
         cnt_ff <= cnt_in;
      end
   end

   assign s3_valid       = valid_ff;
   assign s3_pixel_row   = pix_ff;
   assign s3_pixel_count = cnt_ff;

endmodule

// File: hdl/character_row_dot_stretcher.sv
`timescale 1ns / 1ps
// Character row generator with dot stretching for a text terminal.
// Channels: req_ takes load items (tuser 0: write one glyph byte) and render
// items (tuser 1: character code, scan row, line type); rsp_ returns one
// pixel row item per render, none per load. csr_ writes the reverse
// attribute mode bit and is always ready; the user writes it only while
// the block idles; the block itself does not enforce this. A render passes
// through the address stage, glyph store read, stretch stage and output register to rsp_.
// Throughput: one item per cycle while the skid register is empty.
// A load is written into the store at its acceptance edge, so any later
// render sees it.
// Reset clears all valid bits and the mode bit; the glyph store is not
// cleared and must be loaded before use.
// When rsp_tready stays low, one more row parks in a skid register and
// req_tready then drops until it drains; nothing is lost or repeated.
// Depends on crds_pkg, crds_map, crds_store, crds_stretch and the assert header.
`include "character_row_dot_stretcher_assert.svh"

module character_row_dot_stretcher import crds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // item in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [10:0] glyph_address, [18:11] glyph_byte, [26:19] char_code,
   // [30:27] scan_row, [32:31] line_type, [39:33] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] op
   input  logic                  req_tuser,
   // item out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [19:0] pixel_row, [24:20] pixel_count, [31:25] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // mode register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_data
);

   logic                  advance;
   logic                  accept;
   logic                  mode_ff;
   logic                  s1_valid, s2_valid, s3_valid;
   logic [ADDR_W-1:0]     s1_addr;
   ctl_type               s1_ctl, s2_ctl;
   logic [BYTE_W-1:0]     s2_byte;
   logic [PIX_W-1:0]      s3_pixel_row;
   logic [CNT_W-1:0]      s3_pixel_count;
   logic                  out_valid_ff;
   logic [PIX_W+CNT_W-1:0] out_data_ff;
   logic                  skid_valid_ff;
   logic [PIX_W+CNT_W-1:0] skid_data_ff;
   logic [PIX_W+CNT_W-1:0] s3_data;

   // field split of the request
   logic [ADDR_W-1:0] req_glyph_address;
   logic [BYTE_W-1:0] req_glyph_byte;
   logic [CODE_W-1:0] req_char_code;
   logic [SCAN_W-1:0] req_scan_row;
   logic [1:0]        req_line_type;

   assign req_glyph_address = req_tdata[10:0];
   assign req_glyph_byte    = req_tdata[18:11];
   assign req_char_code     = req_tdata[26:19];
   assign req_scan_row      = req_tdata[30:27];
   assign req_line_type     = req_tdata[32:31];

   // the whole pipe moves while the skid register is empty
   assign advance    = !skid_valid_ff;
   assign req_tready = advance;
   assign accept     = req_tvalid & req_tready;

   // mode register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid & csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   crds_map u_map (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (accept & (req_tuser == OP_RENDER)),
      .char_code    (req_char_code),
      .scan_row     (req_scan_row),
      .line_type    (req_line_type),
      .reverse_mode (mode_ff),
      .s1_valid     (s1_valid),
      .s1_addr      (s1_addr),
      .s1_ctl       (s1_ctl)
   );

   crds_store u_store (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .wr_en    (accept & (req_tuser == OP_LOAD)),
      .wr_addr  (req_glyph_address),
      .wr_data  (req_glyph_byte),
      .s1_valid (s1_valid),
      .s1_addr  (s1_addr),
      .s1_ctl   (s1_ctl),
      .s2_valid (s2_valid),
      .s2_byte  (s2_byte),
      .s2_ctl   (s2_ctl)
   );

   crds_stretch u_stretch (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .s2_valid       (s2_valid),
      .s2_byte        (s2_byte),
      .s2_ctl         (s2_ctl),
      .s3_valid       (s3_valid),
      .s3_pixel_row   (s3_pixel_row),
      .s3_pixel_count (s3_pixel_count)
   );

   assign s3_data = {s3_pixel_count, s3_pixel_row};

   // output register with skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (out_valid_ff && !rsp_tready) begin
         skid_valid_ff <= s3_valid;
      end else begin
         out_valid_ff <= s3_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (out_valid_ff && !rsp_tready) begin
         skid_data_ff <= s3_data;
      end else begin
         out_data_ff <= s3_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PIX_W-CNT_W){1'b0}}, out_data_ff};

   // checks
   `CRDS_ASSERT_NOW(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `CRDS_ASSERT_NOW(a_count_legal, clock, reset, rsp_tvalid,
      (rsp_tdata[24:20] == 5'd10) || (rsp_tdata[24:20] == 5'd20))
   `CRDS_ASSERT_NOW(a_narrow_high_dark, clock, reset,
      rsp_tvalid && (rsp_tdata[24:20] == 5'd10), rsp_tdata[19:10] == 10'd0)
   `CRDS_ASSERT_NEXT(a_skid_drains, clock, reset,
      skid_valid_ff && rsp_tready, !skid_valid_ff && out_valid_ff)

endmodule
